// ===== hw/rtl/quaternion_heading_difference_defines.svh =====
// ----------------------------------------------------------------------------
// Quaternion heading difference: assertion macros
// Concurrent assertion helpers. They expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_HEADING_DIFFERENCE_DEFINES_SVH
`define QUATERNION_HEADING_DIFFERENCE_DEFINES_SVH

`ifndef SYNTHESIS
`define QHD_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rs) (ante) |-> (cons)) \
    else $error("qhd assertion failed");
`define QHD_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rs) (ante) |=> (cons)) \
    else $error("qhd assertion failed");
`else
`define QHD_ASSERT_IMPL(lbl, ck, rs, ante, cons)
`define QHD_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif

`endif

// ===== hw/rtl/qhd_pkg.sv =====
// ----------------------------------------------------------------------------
// Quaternion heading difference package
// Widths, angle constants, the arctangent table and the pipeline data types.
// ----------------------------------------------------------------------------
package qhd_pkg;

  localparam int DATA_W           = 16;
  localparam int PROD_W           = 2 * DATA_W;
  localparam int CORD_W           = 36;
  localparam int ANG_W            = 24;
  localparam int DELTA_W          = 17;
  localparam int ANGLE_ITERATIONS = 16;
  localparam int MAX_ITER         = 32;
  localparam int ITERS            = (ANGLE_ITERATIONS > MAX_ITER) ? MAX_ITER : ANGLE_ITERATIONS;
  localparam int ITER_W           = $clog2(MAX_ITER);
  localparam int STAGES           = ITERS + 3;
  localparam int ROUND_BIAS       = 64;
  localparam int ROUND_SHIFT      = 7;
  localparam int IN_TDATA_W       = 8 * DATA_W;
  localparam int OUT_TDATA_W      = 24;

  localparam logic signed [ANG_W-1:0]   HALF_PI_Q20     = ANG_W'(1647099);
  localparam logic signed [DELTA_W-1:0] TWO_PI_Q13      = DELTA_W'(51472);
  localparam logic signed [DELTA_W-1:0] NEG_TWO_PI_Q13  = -DELTA_W'(51472);

  typedef struct packed {
    logic signed [DATA_W-1:0] w;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] ww;
    logic signed [PROD_W-1:0] xx;
    logic signed [PROD_W-1:0] yy;
    logic signed [PROD_W-1:0] zz;
    logic signed [PROD_W-1:0] xy;
    logic signed [PROD_W-1:0] zw;
  } prod_t;

  typedef struct packed {
    logic signed [CORD_W-1:0] x;
    logic signed [CORD_W-1:0] y;
    logic signed [ANG_W-1:0]  ang;
    logic                     zero;
  } lane_t;

  typedef struct packed {
    lane_t a;
    lane_t b;
    logic  deg;
  } cordic_t;

  function automatic logic signed [ANG_W-1:0] atan_q20(logic [ITER_W-1:0] idx);
    logic signed [ANG_W-1:0] t;
    case (idx)
      5'd0:    t = ANG_W'(823550);
      5'd1:    t = ANG_W'(486170);
      5'd2:    t = ANG_W'(256879);
      5'd3:    t = ANG_W'(130396);
      5'd4:    t = ANG_W'(65451);
      5'd5:    t = ANG_W'(32757);
      5'd6:    t = ANG_W'(16383);
      5'd7:    t = ANG_W'(8192);
      5'd8:    t = ANG_W'(4096);
      5'd9:    t = ANG_W'(2048);
      5'd10:   t = ANG_W'(1024);
      5'd11:   t = ANG_W'(512);
      5'd12:   t = ANG_W'(256);
      5'd13:   t = ANG_W'(128);
      5'd14:   t = ANG_W'(64);
      5'd15:   t = ANG_W'(32);
      5'd16:   t = ANG_W'(16);
      5'd17:   t = ANG_W'(8);
      5'd18:   t = ANG_W'(4);
      5'd19:   t = ANG_W'(2);
      5'd20:   t = ANG_W'(1);
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// ===== hw/rtl/qhd_axis.sv =====
// ----------------------------------------------------------------------------
// Forward axis front end
// Two stages: the quaternion products, then the scaled forward axis of each
// quaternion with the quadrant pre-rotation that starts the vectoring CORDIC.
// ----------------------------------------------------------------------------
module qhd_axis (
  input  logic             clk,
  input  logic             load_prod,
  input  logic             load_axis,
  input  qhd_pkg::quat_t   qa,
  input  qhd_pkg::quat_t   qb,
  output qhd_pkg::cordic_t axis_o
);

  function automatic qhd_pkg::prod_t form_prod(qhd_pkg::quat_t q);
    qhd_pkg::prod_t p;
    p.ww = qhd_pkg::PROD_W'(q.w) * qhd_pkg::PROD_W'(q.w);
    p.xx = qhd_pkg::PROD_W'(q.x) * qhd_pkg::PROD_W'(q.x);
    p.yy = qhd_pkg::PROD_W'(q.y) * qhd_pkg::PROD_W'(q.y);
    p.zz = qhd_pkg::PROD_W'(q.z) * qhd_pkg::PROD_W'(q.z);
    p.xy = qhd_pkg::PROD_W'(q.x) * qhd_pkg::PROD_W'(q.y);
    p.zw = qhd_pkg::PROD_W'(q.z) * qhd_pkg::PROD_W'(q.w);
    return p;
  endfunction

  function automatic qhd_pkg::lane_t prerotate(qhd_pkg::prod_t p);
    logic signed [qhd_pkg::CORD_W-1:0] fa;
    logic signed [qhd_pkg::CORD_W-1:0] fb;
    qhd_pkg::lane_t l;
    fa = qhd_pkg::CORD_W'(p.ww) + qhd_pkg::CORD_W'(p.xx)
       - qhd_pkg::CORD_W'(p.yy) - qhd_pkg::CORD_W'(p.zz);
    fb = (qhd_pkg::CORD_W'(p.xy) + qhd_pkg::CORD_W'(p.zw)) <<< 1;
    l.zero = (fa == '0) && (fb == '0);
    if (fb < 0) begin
      if (fa >= 0) begin
        l.x   = fa;
        l.y   = -fb;
        l.ang = qhd_pkg::HALF_PI_Q20;
      end else begin
        l.x   = -fa;
        l.y   = fb;
        l.ang = -qhd_pkg::HALF_PI_Q20;
      end
    end else begin
      l.x   = fb;
      l.y   = fa;
      l.ang = '0;
    end
    return l;
  endfunction

  qhd_pkg::prod_t   pa_r;
  qhd_pkg::prod_t   pb_r;
  logic             deg_r;
  qhd_pkg::cordic_t axis_r;
  qhd_pkg::cordic_t axis_nxt;

  always_comb begin
    axis_nxt.a   = prerotate(pa_r);
    axis_nxt.b   = prerotate(pb_r);
    axis_nxt.deg = deg_r;
  end

  always_ff @(posedge clk) begin
    if (load_prod) begin
      pa_r  <= form_prod(qa);
      pb_r  <= form_prod(qb);
      deg_r <= (qa == '0) || (qb == '0);
    end
    if (load_axis) begin
      axis_r <= axis_nxt;
    end
  end

  assign axis_o = axis_r;

endmodule

// ===== hw/rtl/qhd_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// Vectoring CORDIC stage
// One micro-rotation for both quaternion lanes, with a register at the end.
// ----------------------------------------------------------------------------
module qhd_cordic_stage (
  input  logic                         clk,
  input  logic                         en,
  input  logic [qhd_pkg::ITER_W-1:0]   iter,
  input  qhd_pkg::cordic_t             d_i,
  output qhd_pkg::cordic_t             d_o
);

  function automatic qhd_pkg::lane_t rotate(qhd_pkg::lane_t l, logic [qhd_pkg::ITER_W-1:0] k);
    logic signed [qhd_pkg::CORD_W-1:0] vx;
    logic signed [qhd_pkg::CORD_W-1:0] vy;
    logic signed [qhd_pkg::CORD_W-1:0] dx;
    logic signed [qhd_pkg::CORD_W-1:0] dy;
    logic signed [qhd_pkg::ANG_W-1:0]  t;
    qhd_pkg::lane_t r;
    vx = l.x;
    vy = l.y;
    dx = vy >>> k;
    dy = vx >>> k;
    t  = qhd_pkg::atan_q20(k);
    r.zero = l.zero;
    if (!vy[qhd_pkg::CORD_W-1]) begin
      r.x   = vx + dx;
      r.y   = vy - dy;
      r.ang = l.ang + t;
    end else begin
      r.x   = vx - dx;
      r.y   = vy + dy;
      r.ang = l.ang - t;
    end
    return r;
  endfunction

  qhd_pkg::cordic_t d_r;
  qhd_pkg::cordic_t d_nxt;

  always_comb begin
    d_nxt.a   = rotate(d_i.a, iter);
    d_nxt.b   = rotate(d_i.b, iter);
    d_nxt.deg = d_i.deg;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule

// ===== hw/rtl/qhd_delta.sv =====
// ----------------------------------------------------------------------------
// Heading difference output stage
// Subtracts the two headings, rounds from Q.20 to Q3.13 and saturates.
// ----------------------------------------------------------------------------
module qhd_delta (
  input  logic                                clk,
  input  logic                                en,
  input  qhd_pkg::cordic_t                    d_i,
  output logic signed [qhd_pkg::DELTA_W-1:0]  heading_delta,
  output logic                                degenerate
);

  localparam int DIFF_W = qhd_pkg::ANG_W + 1;

  logic signed [DIFF_W-1:0]           ang_a;
  logic signed [DIFF_W-1:0]           ang_b;
  logic signed [DIFF_W-1:0]           diff;
  logic signed [DIFF_W-1:0]           rnd;
  logic signed [qhd_pkg::DELTA_W-1:0] delta_r;
  logic signed [qhd_pkg::DELTA_W-1:0] delta_nxt;
  logic                               deg_r;

  always_comb begin
    ang_a = d_i.a.zero ? '0 : DIFF_W'(d_i.a.ang);
    ang_b = d_i.b.zero ? '0 : DIFF_W'(d_i.b.ang);
    diff  = ang_a - ang_b;
    rnd   = (diff + DIFF_W'(qhd_pkg::ROUND_BIAS)) >>> qhd_pkg::ROUND_SHIFT;
    if (d_i.deg) begin
      delta_nxt = '0;
    end else if (rnd > DIFF_W'(qhd_pkg::TWO_PI_Q13)) begin
      delta_nxt = qhd_pkg::TWO_PI_Q13;
    end else if (rnd < DIFF_W'(qhd_pkg::NEG_TWO_PI_Q13)) begin
      delta_nxt = qhd_pkg::NEG_TWO_PI_Q13;
    end else begin
      delta_nxt = qhd_pkg::DELTA_W'(rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      delta_r <= delta_nxt;
      deg_r   <= d_i.deg;
    end
  end

  assign heading_delta = delta_r;
  assign degenerate    = deg_r;

endmodule

// ===== hw/rtl/quaternion_heading_difference.sv =====
// ----------------------------------------------------------------------------
// Quaternion heading difference
// The pipeline has one product stage, one axis stage, one CORDIC stage
// per iteration and one output stage. Throughput is one request per cycle
// while the output is not stalled; a stage whose successor is full holds,
// and empty stages ahead of a stall still fill.
// Reset clears the stage valid bits only; the datapath registers hold payload.
// ----------------------------------------------------------------------------
`include "quaternion_heading_difference_defines.svh"

module quaternion_heading_difference (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, 16 bits each from bit 0 up.
  input  logic [qhd_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // heading_delta [16:0], degenerate [17], zero fill [23:18].
  output logic [qhd_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int S  = qhd_pkg::STAGES;
  localparam int DW = qhd_pkg::DATA_W;

  qhd_pkg::quat_t   qa;
  qhd_pkg::quat_t   qb;
  qhd_pkg::cordic_t stage_d [0:qhd_pkg::ITERS];
  logic [S-1:0]     v_r;
  logic [S-1:0]     v_nxt;
  logic [S:0]       adv;
  logic signed [qhd_pkg::DELTA_W-1:0] heading_delta;
  logic                               degenerate;

  assign qa = '{w: in_tdata[0*DW +: DW], x: in_tdata[1*DW +: DW],
                y: in_tdata[2*DW +: DW], z: in_tdata[3*DW +: DW]};
  assign qb = '{w: in_tdata[4*DW +: DW], x: in_tdata[5*DW +: DW],
                y: in_tdata[6*DW +: DW], z: in_tdata[7*DW +: DW]};

  assign adv[S] = out_tready;

  for (genvar i = 0; i < S; i++) begin : g_adv
    assign adv[i] = ~v_r[i] | adv[i+1];
  end

  assign v_nxt = (adv[S-1:0] & {v_r[S-2:0], in_tvalid}) | (~adv[S-1:0] & v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  qhd_axis u_axis (
    .clk       (clk),
    .load_prod (adv[0]),
    .load_axis (adv[1]),
    .qa        (qa),
    .qb        (qb),
    .axis_o    (stage_d[0])
  );

  for (genvar k = 0; k < qhd_pkg::ITERS; k++) begin : g_cordic
    qhd_cordic_stage u_stage (
      .clk  (clk),
      .en   (adv[k+2]),
      .iter (qhd_pkg::ITER_W'(k)),
      .d_i  (stage_d[k]),
      .d_o  (stage_d[k+1])
    );
  end

  qhd_delta u_delta (
    .clk           (clk),
    .en            (adv[S-1]),
    .d_i           (stage_d[qhd_pkg::ITERS]),
    .heading_delta (heading_delta),
    .degenerate    (degenerate)
  );

  assign in_tready  = adv[0];
  assign out_tvalid = v_r[S-1];
  assign out_tdata  = {{(qhd_pkg::OUT_TDATA_W - qhd_pkg::DELTA_W - 1){1'b0}},
                       degenerate, heading_delta};

  `QHD_ASSERT_IMPL(a_deg_gives_zero, clk, rst_n, out_tvalid && degenerate, heading_delta == '0)
  `QHD_ASSERT_IMPL(a_delta_in_range, clk, rst_n, out_tvalid, (heading_delta <= qhd_pkg::TWO_PI_Q13) && (heading_delta >= qhd_pkg::NEG_TWO_PI_Q13))
  `QHD_ASSERT_NEXT(a_accept_fills_entry, clk, rst_n, in_tvalid && in_tready, v_r[0])
  `QHD_ASSERT_NEXT(a_stalled_out_holds, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(heading_delta) && $stable(degenerate))

endmodule
